/* rtl/core/box_blur_3x3_clipped_macros.svh */
// assertion helpers for the checker file bb3_chk.sv
`ifndef BOX_BLUR_3X3_CLIPPED_MACROS_SVH
`define BOX_BLUR_3X3_CLIPPED_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define BB3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define BB3_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bb3_pkg.sv */
package bb3_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int LINE_AW     = $clog2(MAX_COLS);
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pixel_t;

    // control from the sequencer to the window unit
    typedef struct packed {
        logic       shift;
        logic       sum_en;
        logic [1:0] rlo;
        logic [1:0] clo;
    } win_ctrl_t;

    // ceil(2^16 / n) for n = (3 - rlo) * (3 - clo); exact for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] mean_recip(input logic [1:0] rlo,
                                                      input logic [1:0] clo);
        logic [RECIP_W-1:0] m;
        case ({rlo, clo})
            4'b0000: m = RECIP_W'(7282);
            4'b0001: m = RECIP_W'(10923);
            4'b0010: m = RECIP_W'(21846);
            4'b0100: m = RECIP_W'(10923);
            4'b0101: m = RECIP_W'(16384);
            4'b0110: m = RECIP_W'(32768);
            4'b1000: m = RECIP_W'(21846);
            4'b1001: m = RECIP_W'(32768);
            4'b1010: m = RECIP_W'(65536);
            default: m = RECIP_W'(65536);
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/bb3_ram.sv */
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/bb3_window.sv */
module bb3_window import bb3_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  win_ctrl_t        ctrl,
    input  pixel_t           older,
    input  pixel_t           recent,
    input  pixel_t           newest,
    output logic [SUM_W-1:0] sum
);

    pixel_t           win_reg  [9];
    pixel_t           win_next [9];
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.shift)
        begin
            for (int rr = 0; rr < 3; rr++)
            begin
                win_next[rr * 3]     = win_reg[rr * 3 + 1];
                win_next[rr * 3 + 1] = win_reg[rr * 3 + 2];
            end
            win_next[2] = older;
            win_next[5] = recent;
            win_next[8] = newest;
        end
    end

    // clipped neighbourhood: window rows rlo..2, columns clo..2
    always_comb
    begin
        sum_next = '0;
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int cc = 0; cc < 3; cc++)
            begin
                if ((2'(rr) >= ctrl.rlo) && (2'(cc) >= ctrl.clo))
                begin
                    sum_next = sum_next + SUM_W'(win_reg[rr * 3 + cc]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

/* rtl/core/bb3_mean.sv */
module bb3_mean import bb3_pkg::*; (
    input  logic [SUM_W-1:0] sum,
    input  logic [1:0]       rlo,
    input  logic [1:0]       clo,
    output pixel_t           mean
);

    logic [SUM_W+RECIP_W-1:0] product;

    // divide by the pixel count through a reciprocal multiply
    assign product = (SUM_W + RECIP_W)'(sum) * (SUM_W + RECIP_W)'(mean_recip(rlo, clo));
    assign mean    = product[RECIP_SHIFT +: PIX_W];

endmodule

/* rtl/core/box_blur_3x3_clipped.sv */
// 3x3 clipped box blur over a raster pixel stream.
// input channel: in_valid / in_stall carry one pixel word (pixel_in) per
// transfer, frames arrive in raster order of image_rows x image_cols.
// output channel: out_valid / out_stall carry blurred words with their
// out_row / out_col position; run_last marks the final word caused by
// one input pixel. a pixel gives zero to four words.
// config: cfg_write with cfg_index 0 (rows) or 1 (cols) and cfg_data;
// a write to either register restarts the frame at row 0, column 0. write only when idle.
// sequence: when a pixel is taken the two line memories are read; in
// S_READ the window shifts in the read column and the memories are
// written back, then each word passes a sum state (S_SUM) and a divide
// state (S_EMIT) that loads the output register. a new pixel is taken
// only once all words of the last one are loaded. the line memory read
// and the shared sum/divide unit set this order.
// the output register holds a word while out_stall is high; the next
// pixel can be taken meanwhile, and a further word waits for the
// register to free up. reset clears the window, counters and output
// valid and loads 5 x 5 as the frame size.
module box_blur_3x3_clipped import bb3_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic [PIX_W-1:0]     blurred,
    output logic                 run_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;

    pixel_t                px_reg;
    logic [ROW_W-1:0]      cur_row_reg;
    logic [COL_W-1:0]      cur_col_reg;
    logic [3:0]            pend_reg;
    logic [1:0]            rlo_prev_reg;
    logic [1:0]            rlo_last_reg;
    logic [1:0]            clo_mid_reg;
    logic [1:0]            clo_end_reg;
    logic [1:0]            sel_rlo_reg;
    logic [1:0]            sel_clo_reg;
    logic [ROW_W-1:0]      sel_row_reg;
    logic [COL_W-1:0]      sel_col_reg;
    logic                  sel_last_reg;

    logic                  out_valid_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    pixel_t                blurred_reg;
    logic                  run_last_reg;

    logic [ROWS_CFG_W-1:0] eff_rows;
    logic [COLS_CFG_W-1:0] eff_cols;
    logic [ROWS_CFG_W-1:0] rows_m1;
    logic [COLS_CFG_W-1:0] cols_m1;
    logic [COL_W-1:0]      col_clamp;
    logic                  endrow;
    logic                  lastrow;
    logic [3:0]            pend_new;
    logic                  accept;
    logic                  out_free;

    logic                  sel_pair;
    logic                  sel_even;
    logic [3:0]            pend_rest;
    logic [1:0]            sel_rlo;
    logic [1:0]            sel_clo;
    logic [ROW_W-1:0]      sel_row;
    logic [COL_W-1:0]      sel_col;

    pixel_t                older_rd;
    pixel_t                recent_rd;
    logic                  line_wr;
    win_ctrl_t             win_ctrl;
    logic [SUM_W-1:0]      win_sum;
    pixel_t                mean;

    // frame size as the datapath sees it: zero acts as one, large values saturate
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            eff_rows = ROWS_CFG_W'(1);
        end
        else if (rows_cfg_reg > ROWS_CFG_W'(MAX_ROWS))
        begin
            eff_rows = ROWS_CFG_W'(MAX_ROWS);
        end
        else
        begin
            eff_rows = rows_cfg_reg;
        end
        if (cols_cfg_reg == '0)
        begin
            eff_cols = COLS_CFG_W'(1);
        end
        else if (cols_cfg_reg > COLS_CFG_W'(MAX_COLS))
        begin
            eff_cols = COLS_CFG_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = cols_cfg_reg;
        end
    end

    assign rows_m1   = eff_rows - ROWS_CFG_W'(1);
    assign cols_m1   = eff_cols - COLS_CFG_W'(1);
    assign col_clamp = (COLS_CFG_W'(col_reg) >= eff_cols) ? cols_m1[COL_W-1:0] : col_reg;
    assign endrow    = (COLS_CFG_W'(cur_col_reg) >= cols_m1);
    assign lastrow   = (ROWS_CFG_W'(cur_row_reg) >= rows_m1);

    assign pend_new[0] = (cur_row_reg != '0) && (cur_col_reg != '0);
    assign pend_new[1] = (cur_row_reg != '0) && endrow;
    assign pend_new[2] = lastrow && (cur_col_reg != '0);
    assign pend_new[3] = lastrow && endrow;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // lowest pending word first: previous row before current, left column first
    assign sel_pair  = pend_reg[0] || pend_reg[1];
    assign sel_even  = sel_pair ? pend_reg[0] : pend_reg[2];
    assign pend_rest = pend_reg & (pend_reg - 4'd1);
    assign sel_rlo   = sel_pair ? rlo_prev_reg : rlo_last_reg;
    assign sel_clo   = sel_even ? clo_mid_reg : clo_end_reg;
    assign sel_row   = sel_pair ? (cur_row_reg - ROW_W'(1)) : cur_row_reg;
    assign sel_col   = sel_even ? (cur_col_reg - COL_W'(1)) : cur_col_reg;

    assign line_wr         = (state_reg == S_READ);
    assign win_ctrl.shift  = (state_reg == S_READ);
    assign win_ctrl.sum_en = (state_reg == S_SUM);
    assign win_ctrl.rlo    = sel_rlo;
    assign win_ctrl.clo    = sel_clo;

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_older_line (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (LINE_AW'(cur_col_reg)),
        .wr_data (recent_rd),
        .rd_addr (LINE_AW'(col_clamp)),
        .rd_data (older_rd)
    );

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_recent_line (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (LINE_AW'(cur_col_reg)),
        .wr_data (px_reg),
        .rd_addr (LINE_AW'(col_clamp)),
        .rd_data (recent_rd)
    );

    bb3_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .older  (older_rd),
        .recent (recent_rd),
        .newest (px_reg),
        .sum    (win_sum)
    );

    bb3_mean u_mean (
        .sum  (win_sum),
        .rlo  (sel_rlo_reg),
        .clo  (sel_clo_reg),
        .mean (mean)
    );

    // frame size and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_CFG_W'(5);
            cols_cfg_reg <= COLS_CFG_W'(5);
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS:
                begin
                    rows_cfg_reg <= cfg_data[ROWS_CFG_W-1:0];
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                REG_IMAGE_COLS:
                begin
                    cols_cfg_reg <= cfg_data[COLS_CFG_W-1:0];
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_READ)
        begin
            if (endrow)
            begin
                col_reg <= '0;
                row_reg <= lastrow ? '0 : (cur_row_reg + ROW_W'(1));
            end
            else
            begin
                col_reg <= cur_col_reg + COL_W'(1);
            end
        end
    end

    // word in flight and its pending results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg      <= pixel_in;
            cur_row_reg <= row_reg;
            cur_col_reg <= col_clamp;
        end
        if (state_reg == S_READ)
        begin
            rlo_prev_reg <= (cur_row_reg >= ROW_W'(2)) ? 2'd0 : 2'd1;
            rlo_last_reg <= (cur_row_reg != '0) ? 2'd1 : 2'd2;
            clo_mid_reg  <= (cur_col_reg >= COL_W'(2)) ? 2'd0 : 2'd1;
            clo_end_reg  <= (cur_col_reg != '0) ? 2'd1 : 2'd2;
        end
        if (state_reg == S_SUM)
        begin
            sel_rlo_reg  <= sel_rlo;
            sel_clo_reg  <= sel_clo;
            sel_row_reg  <= sel_row;
            sel_col_reg  <= sel_col;
            sel_last_reg <= (pend_rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            blurred_reg   <= '0;
            run_last_reg  <= 1'b0;
        end
        else
        begin
            // in S_EMIT a taken word is replaced below
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    pend_reg  <= pend_new;
                    state_reg <= (pend_new == '0) ? S_IDLE : S_SUM;
                end
                S_SUM:
                begin
                    pend_reg  <= pend_rest;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= sel_row_reg;
                        out_col_reg   <= sel_col_reg;
                        blurred_reg   <= mean;
                        run_last_reg  <= sel_last_reg;
                        state_reg     <= (pend_reg == '0) ? S_IDLE : S_SUM;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign blurred   = blurred_reg;
    assign run_last  = run_last_reg;

endmodule

/* rtl/core/bb3_chk.sv */
`include "box_blur_3x3_clipped_macros.svh"

module bb3_chk import bb3_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ROW_W-1:0] out_row,
    input logic [COL_W-1:0] out_col,
    input logic [PIX_W-1:0] blurred,
    input logic             run_last
);

    logic [ROW_W+COL_W+PIX_W:0] out_word;

    assign out_word = {out_row, out_col, blurred, run_last};

    `BB3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "word dropped under stall")
    `BB3_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled word changed")
    `BB3_ASSERT_NEXT(a_one_pixel, in_valid && !in_stall, in_stall, "second pixel taken while busy")
    `BB3_ASSERT_NOW(a_load_busy, $rose(out_valid), $past(in_stall), "word without work in flight")

endmodule

bind box_blur_3x3_clipped bb3_chk u_chk (.*);

/* tb/box_blur_3x3_clipped_tb.sv */
`timescale 1ns / 1ps

module box_blur_3x3_clipped_tb;
    import bb3_pkg::*;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 80;

    typedef enum logic [1:0] {
        STIM_PIXEL,
        STIM_QUIET,
        STIM_TYPED,
        STIM_WRITE
    } stim_kind_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           value;
        logic             last;
    } blur_word_t;

    typedef struct packed {
        stim_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        pixel_t               px;
        blur_word_t           typed;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     out_col;
    logic [PIX_W-1:0]     blurred;
    logic                 run_last;

    box_blur_3x3_clipped u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .blurred   (blurred),
        .run_last  (run_last)
    );

    // blur state as the block should hold it
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    int unsigned           next_row;
    int unsigned           next_col;
    pixel_t                older_mem [MAX_COLS];
    pixel_t                recent_mem [MAX_COLS];
    pixel_t                win [9];

    blur_word_t step_words[$];
    blur_word_t pending_words[$];
    blur_word_t want;
    stim_row_t  directed_rows[$];

    int unsigned mismatch_count;
    bit          send_steady;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned clip_size(int unsigned v, int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    // mean over window rows rlo..2 and window columns clo..2
    function automatic void add_mean(int unsigned orow, int unsigned ocol,
                                     int unsigned rlo, int unsigned clo);
        int unsigned sum;
        int unsigned cnt;
        blur_word_t  w;
        sum = 0;
        cnt = 0;
        for (int unsigned rr = rlo; rr < 3; rr++)
            for (int unsigned cc = clo; cc < 3; cc++)
            begin
                sum += win[rr * 3 + cc];
                cnt++;
            end
        w.row   = ROW_W'(orow);
        w.col   = COL_W'(ocol);
        w.value = PIX_W'(sum / cnt);
        w.last  = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void predict_pixel(pixel_t px);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        int unsigned rlo;
        int unsigned clo_mid;
        int unsigned clo_end;
        pixel_t      up2;
        pixel_t      up1;
        bit          endrow;
        bit          lastrow;
        blur_word_t  w;
        nrows = clip_size(rows_reg, MAX_ROWS);
        ncols = clip_size(cols_reg, MAX_COLS);
        r = next_row;
        c = next_col;
        if (c >= ncols)
            c = ncols - 1;
        up2 = older_mem[c];
        up1 = recent_mem[c];
        older_mem[c]  = up1;
        recent_mem[c] = px;
        for (int rr = 0; rr < 3; rr++)
        begin
            win[rr * 3]     = win[rr * 3 + 1];
            win[rr * 3 + 1] = win[rr * 3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = px;
        endrow  = (c >= ncols - 1);
        lastrow = (r >= nrows - 1);
        clo_mid = (c >= 2) ? 0 : 1;
        clo_end = (c >= 1) ? 1 : 2;
        step_words.delete();
        if (r >= 1)
        begin
            rlo = (r >= 2) ? 0 : 1;
            if (c >= 1)
                add_mean(r - 1, c - 1, rlo, clo_mid);
            if (endrow)
                add_mean(r - 1, c, rlo, clo_end);
        end
        // the last row is flushed while it streams in
        if (lastrow)
        begin
            rlo = (r >= 1) ? 1 : 2;
            if (c >= 1)
                add_mean(r, c - 1, rlo, clo_mid);
            if (endrow)
                add_mean(r, c, rlo, clo_end);
        end
        if (step_words.size() > 0)
        begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        if (endrow)
        begin
            next_col = 0;
            next_row = lastrow ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    function automatic void commit_words();
        foreach (step_words[i])
            pending_words.push_back(step_words[i]);
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (send_steady || p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 20);
    endfunction

    function automatic pixel_t pick_pixel();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p < 2)
            return 8'h00;
        if (p < 4)
            return 8'hFF;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic void dir_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t s;
        s = '0;
        s.kind = STIM_WRITE;
        s.idx  = idx;
        s.data = data;
        directed_rows.push_back(s);
    endfunction

    function automatic void dir_pixel(stim_kind_t kind, pixel_t px, int unsigned r,
                                      int unsigned c, int unsigned v);
        stim_row_t s;
        s = '0;
        s.kind        = kind;
        s.px          = px;
        s.typed.row   = ROW_W'(r);
        s.typed.col   = COL_W'(c);
        s.typed.value = PIX_W'(v);
        s.typed.last  = 1'b1;
        directed_rows.push_back(s);
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        // a pixel with no word may still be in the line memory pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_ROWS:
            begin
                rows_reg = data[ROWS_CFG_W-1:0];
                next_row = 0;
                next_col = 0;
            end
            REG_IMAGE_COLS:
            begin
                cols_reg = data[COLS_CFG_W-1:0];
                next_row = 0;
                next_col = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_pixel(pixel_t px);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(px);
    endtask

    task automatic stream_pixels(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
        begin
            send_pixel(pick_pixel());
            commit_words();
        end
    endtask

    // receiver: random stall runs, one long hold-off on request
    initial
    begin
        int unsigned run;
        int unsigned len;
        int unsigned p;
        out_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            p = $urandom_range(0, 99);
            run = (p < 10) ? $urandom_range(40, 80) : $urandom_range(1, 6);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            p = $urandom_range(0, 99);
            if (p < 80)
                len = $urandom_range(1, 3);
            else if (p < 95)
                len = $urandom_range(4, 10);
            else
                len = $urandom_range(11, 20);
            out_stall <= 1'b1;
            repeat (len) @(posedge clk);
        end
    end

    // every accepted word is matched against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word row %0d col %0d blurred %0d last %0b",
                         $time, out_row, out_col, blurred, run_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_row !== want.row || out_col !== want.col ||
                    blurred !== want.value || run_last !== want.last)
                begin
                    $display("%0t: expected row %0d col %0d blurred %0d last %0b",
                             $time, want.row, want.col, want.value, want.last);
                    $display("%0t: actual   row %0d col %0d blurred %0d last %0b",
                             $time, out_row, out_col, blurred, run_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t        s;
        int unsigned      rnd_items;
        int unsigned      phase;
        int unsigned      npix;
        int unsigned      p;
        logic [CFG_W-1:0] rows_val;
        logic [COLS_CFG_W-1:0] cols_val;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_IMAGE_ROWS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pixel_in  <= '0;
        mismatch_count = 0;
        send_steady = 1'b0;
        hold_req    = 1'b0;
        rows_reg = ROWS_CFG_W'(5);
        cols_reg = COLS_CFG_W'(5);
        next_row = 0;
        next_col = 0;
        foreach (older_mem[i])
        begin
            older_mem[i]  = '0;
            recent_mem[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;

        // default 5 x 5 frame: first-row pixels give no word
        dir_pixel(STIM_QUIET, 8'h00, 0, 0, 0);
        dir_pixel(STIM_QUIET, 8'hFF, 0, 0, 0);
        dir_write(REG_SPARE_A, 13'h1FFF);
        dir_write(REG_SPARE_B, 13'h0AAA);
        dir_pixel(STIM_PIXEL, 8'h80, 0, 0, 0);
        // zero registers act as a 1 x 1 frame, every pixel is its own mean
        dir_write(REG_IMAGE_ROWS, 13'd0);
        dir_write(REG_IMAGE_COLS, 13'd0);
        dir_pixel(STIM_TYPED, 8'hFF, 0, 0, 255);
        dir_pixel(STIM_TYPED, 8'h00, 0, 0, 0);
        dir_pixel(STIM_TYPED, 8'hA5, 0, 0, 165);
        // 2 x 2: the last pixel gives four words
        dir_write(REG_IMAGE_ROWS, 13'd2);
        dir_write(REG_IMAGE_COLS, 13'd2);
        dir_pixel(STIM_PIXEL, 8'hFF, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hFF, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hFF, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hFE, 0, 0, 0);
        dir_write(REG_IMAGE_ROWS, 13'd3);
        dir_write(REG_IMAGE_COLS, 13'd3);
        for (int k = 0; k < 9; k++)
            dir_pixel(STIM_PIXEL, (k % 2) ? 8'h00 : 8'hFF, 0, 0, 0);
        // single row and single column frames
        dir_write(REG_IMAGE_ROWS, 13'd1);
        dir_pixel(STIM_PIXEL, 8'h00, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hFF, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hFF, 0, 0, 0);
        dir_write(REG_IMAGE_ROWS, 13'd3);
        dir_write(REG_IMAGE_COLS, 13'd1);
        dir_pixel(STIM_PIXEL, 8'h07, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'hC8, 0, 0, 0);
        dir_pixel(STIM_PIXEL, 8'h0D, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            s = directed_rows[i];
            if (s.kind == STIM_WRITE)
                write_reg(s.idx, s.data);
            else
            begin
                send_pixel(s.px);
                if (s.kind == STIM_QUIET)
                    step_words.delete();
                else if (s.kind == STIM_TYPED)
                begin
                    step_words.delete();
                    step_words.push_back(s.typed);
                end
                commit_words();
            end
        end

        rnd_items = 0;
        phase = 0;
        while (rnd_items < RANDOM_PIXELS)
        begin
            p = $urandom_range(0, 99);
            rows_val = (p < 5) ? CFG_W'(0) : CFG_W'($urandom_range(1, 6));
            p = $urandom_range(0, 99);
            if (p < 5)
                cols_val = '0;
            else if (p < 15)
                cols_val = COLS_CFG_W'($urandom_range(12, 16));
            else
                cols_val = COLS_CFG_W'($urandom_range(1, 8));
            if (phase == 1)
            begin
                rows_val = CFG_W'(6);
                cols_val = COLS_CFG_W'(8);
            end
            send_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_W'($urandom_range(0, 8191)));
            p = $urandom_range(0, 9);
            // upper data bits above the column register must be dropped
            if (p < 7 || phase <= 1)
            begin
                write_reg(REG_IMAGE_ROWS, rows_val);
                write_reg(REG_IMAGE_COLS, {2'($urandom_range(0, 3)), cols_val});
            end
            else if (p < 9)
                write_reg(REG_IMAGE_ROWS, rows_val);
            else
                write_reg(REG_IMAGE_COLS, {2'($urandom_range(0, 3)), cols_val});
            npix = clip_size(rows_reg, MAX_ROWS) * clip_size(cols_reg, MAX_COLS);
            npix = npix * $urandom_range(1, 2);
            // broken frame, cut short by the next register write
            if ($urandom_range(0, 6) == 0)
                npix = $urandom_range(1, npix);
            // keep the random part near its pixel budget
            if (phase == 0 && npix > 24)
                npix = 24;
            if (npix > RANDOM_PIXELS - rnd_items)
                npix = RANDOM_PIXELS - rnd_items;
            if (phase == 0)
            begin
                stream_pixels(npix / 2);
                wait_idle();
                stream_pixels(npix - npix / 2);
            end
            else
            begin
                if (phase == 1)
                    hold_req = 1'b1;
                stream_pixels(npix);
            end
            rnd_items += npix;
            phase++;
        end

        // largest and saturating sizes, first pixels of each frame
        send_steady = 1'b0;
        write_reg(REG_IMAGE_ROWS, CFG_W'(MAX_ROWS));
        write_reg(REG_IMAGE_COLS, CFG_W'(MAX_COLS));
        stream_pixels(20);
        write_reg(REG_IMAGE_ROWS, CFG_W'(1));
        write_reg(REG_IMAGE_COLS, CFG_W'(2047));
        stream_pixels(5);
        write_reg(REG_IMAGE_ROWS, CFG_W'(8191));
        write_reg(REG_IMAGE_COLS, CFG_W'(1));
        stream_pixels(5);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
